>>> design/lwss_pkg.sv
// Package for the lattice window swap step.
// Holds grid and window constants, field widths, codes and coordinate helpers.
// No dependencies.
package lwss_pkg;

  localparam int GRID_SIZE     = 64;
  localparam int WINDOW_RADIUS = 20;
  localparam int MOVE_RADIUS   = 10;

  localparam int COORD_W  = $clog2(GRID_SIZE);
  localparam int ADDR_W   = 2 * COORD_W;
  localparam int CELLS    = GRID_SIZE * GRID_SIZE;
  localparam int TYPE_W   = 2;
  localparam int KIND_W   = 2;
  localparam int OFFS_W   = 5;
  localparam int DELTA_W  = 6;
  localparam int WEIGHT_W = 16;
  localparam int POT_W    = 27;
  localparam int CNT_W    = $clog2(2 * WINDOW_RADIUS + 1);
  localparam int WRAP_W   = COORD_W + 3;

  localparam logic [CNT_W-1:0]          WIN_LAST = CNT_W'(2 * WINDOW_RADIUS);
  localparam logic signed [DELTA_W-1:0] WIN_BACK = DELTA_W'(-WINDOW_RADIUS);

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TRIAL = 2'd2;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam logic REG_WEIGHT_EQUAL   = 1'b0;
  localparam logic REG_WEIGHT_UNEQUAL = 1'b1;
  localparam logic [WEIGHT_W-1:0] WEIGHT_EQUAL_RST   = 16'd179;
  localparam logic [WEIGHT_W-1:0] WEIGHT_UNEQUAL_RST = 16'd256;

  // Adds a signed delta smaller than the grid to a coordinate, wrapping around.
  function automatic logic [COORD_W-1:0] wrap_add(input logic [COORD_W-1:0] c,
                                                  input logic signed [DELTA_W-1:0] d);
    logic signed [WRAP_W-1:0] grid_s;
    logic signed [WRAP_W-1:0] v;
    grid_s = WRAP_W'(GRID_SIZE);
    v = $signed({3'b000, c}) + grid_s + WRAP_W'(d);
    if (v >= grid_s) begin
      v = v - grid_s;
    end
    return v[COORD_W-1:0];
  endfunction

  function automatic logic [COORD_W-1:0] coord_inc(input logic [COORD_W-1:0] c);
    return (c == COORD_W'(GRID_SIZE - 1)) ? '0 : c + COORD_W'(1);
  endfunction

  function automatic logic signed [DELTA_W-1:0] clamp_move(
      input logic signed [OFFS_W-1:0] d);
    logic signed [DELTA_W-1:0] dx;
    dx = DELTA_W'(d);
    if (dx > DELTA_W'(MOVE_RADIUS)) begin
      dx = DELTA_W'(MOVE_RADIUS);
    end else if (dx < DELTA_W'(-MOVE_RADIUS)) begin
      dx = DELTA_W'(-MOVE_RADIUS);
    end
    return dx;
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] r,
                                                  input logic [COORD_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(GRID_SIZE) + ADDR_W'(c);
  endfunction

endpackage

>>> design/lwss_if.sv
// Handshake interfaces for the request and result channels.
// Depends on lwss_pkg for field widths.
interface lwss_in_if import lwss_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic [COORD_W-1:0]        row;
  logic [COORD_W-1:0]        col;
  logic [TYPE_W-1:0]         cell_type;
  logic signed [OFFS_W-1:0]  row_offset;
  logic signed [OFFS_W-1:0]  col_offset;

  modport source (output valid, kind, row, col, cell_type, row_offset, col_offset,
                  input ready);
  modport sink   (input valid, kind, row, col, cell_type, row_offset, col_offset,
                  output ready);
endinterface

interface lwss_out_if import lwss_pkg::*;;
  logic               valid;
  logic               ready;
  logic [TYPE_W-1:0]  read_type;
  logic               swapped;
  logic [POT_W-1:0]   source_potential;
  logic [POT_W-1:0]   target_potential;

  modport source (output valid, read_type, swapped, source_potential, target_potential,
                  input ready);
  modport sink   (input valid, read_type, swapped, source_potential, target_potential,
                  output ready);
endinterface

>>> design/lwss_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lwss_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> design/lattice_window_swap_step.sv
// Lattice window swap step: toroidal cell grid with write, read and swap trials.
// Depends on lwss_pkg, lwss_in_if, lwss_out_if and lwss_ram.
//
//   channel   | kind       | beat contents
//   ----------+------------+----------------------------------------------------
//   in_item   | sink       | kind, row, col, cell_type, row_offset, col_offset
//   out_item  | source     | read_type, swapped, source_potential, target_potential
//   APB       | completer  | weight_equal at 0x0, weight_unequal at 0x4
//
// After reset a clearing pass zeroes the 4096-entry grid, one cell per cycle, before
// the first beat is taken; register writes are taken during it.
// A trial makes two window walks of 41x41 cells through the single grid read port,
// one cell per cycle, then, if the source sum is below the target sum, two swap
// writes through the write port.
// One item is worked on at a time; a new beat is taken while a result still waits.
module lattice_window_swap_step import lwss_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  lwss_in_if.sink               in_item,
  lwss_out_if.source            out_item,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int STATE_W = 4;
  localparam logic [STATE_W-1:0] S_CLEAR = 4'd0;
  localparam logic [STATE_W-1:0] S_IDLE  = 4'd1;
  localparam logic [STATE_W-1:0] S_READ  = 4'd2;
  localparam logic [STATE_W-1:0] S_CEN1  = 4'd3;
  localparam logic [STATE_W-1:0] S_CEN2  = 4'd4;
  localparam logic [STATE_W-1:0] S_WALK  = 4'd5;
  localparam logic [STATE_W-1:0] S_DRAIN = 4'd6;
  localparam logic [STATE_W-1:0] S_SAVE  = 4'd7;
  localparam logic [STATE_W-1:0] S_SWAP1 = 4'd8;
  localparam logic [STATE_W-1:0] S_SWAP2 = 4'd9;
  localparam logic [STATE_W-1:0] S_DONE  = 4'd10;

  logic [STATE_W-1:0]  state;
  logic [ADDR_W-1:0]   clr_cnt;
  logic [WEIGHT_W-1:0] weight_equal;
  logic [WEIGHT_W-1:0] weight_unequal;
  logic                phase;
  logic                pend;
  logic                out_valid;

  logic [COORD_W-1:0]  src_r, src_c, tgt_r, tgt_c;
  logic [TYPE_W-1:0]   src_type, tgt_type;
  logic [COORD_W-1:0]  wrow, wcol, wcol_start;
  logic [CNT_W-1:0]    kcnt, lcnt;
  logic [POT_W-1:0]    acc, src_pot, tgt_pot;
  logic [TYPE_W-1:0]   res_read_type;
  logic                res_swapped;
  logic [TYPE_W-1:0]   out_read_type;
  logic                out_swapped;
  logic [POT_W-1:0]    out_src_pot, out_tgt_pot;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [TYPE_W-1:0]   ram_wdata, ram_rdata;

  logic                in_fire;
  logic                cfg_write;
  logic                out_load;
  logic [TYPE_W-1:0]   centre;
  logic [COORD_W-1:0]  walk_base_r, walk_base_c;

  assign in_fire   = in_item.valid && in_item.ready;
  assign cfg_write = psel && penable && pwrite && pready;
  assign out_load  = (state == S_DONE) && (!out_valid || out_item.ready);
  assign centre    = phase ? tgt_type : src_type;
  assign walk_base_r = (state == S_CEN2) ? src_r : tgt_r;
  assign walk_base_c = (state == S_CEN2) ? src_c : tgt_c;

  assign in_item.ready             = (state == S_IDLE);
  assign out_item.valid            = out_valid;
  assign out_item.read_type        = out_read_type;
  assign out_item.swapped          = out_swapped;
  assign out_item.source_potential = out_src_pot;
  assign out_item.target_potential = out_tgt_pot;

  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[CFG_ADDR_W-1])
      REG_WEIGHT_EQUAL:   prdata = 32'(weight_equal);
      REG_WEIGHT_UNEQUAL: prdata = 32'(weight_unequal);
      default:            prdata = '0;
    endcase
  end

  // Grid port steering: the read address follows the window walk unless a
  // centre or single-cell read is due.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_cnt;
    ram_wdata = '0;
    ram_raddr = cell_addr(wrow, wcol);
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_IDLE: begin
        ram_raddr = cell_addr(in_item.row, in_item.col);
        if (in_fire && in_item.kind == KIND_WRITE) begin
          ram_we    = 1'b1;
          ram_waddr = cell_addr(in_item.row, in_item.col);
          ram_wdata = in_item.cell_type;
        end
      end
      S_CEN1: begin
        ram_raddr = cell_addr(tgt_r, tgt_c);
      end
      S_SWAP1: begin
        ram_we    = 1'b1;
        ram_waddr = cell_addr(src_r, src_c);
        ram_wdata = tgt_type;
      end
      S_SWAP2: begin
        ram_we    = 1'b1;
        ram_waddr = cell_addr(tgt_r, tgt_c);
        ram_wdata = src_type;
      end
      default: begin
      end
    endcase
  end

  lwss_ram #(
    .WIDTH (TYPE_W),
    .DEPTH (CELLS)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_cnt        <= '0;
      weight_equal   <= WEIGHT_EQUAL_RST;
      weight_unequal <= WEIGHT_UNEQUAL_RST;
      phase          <= 1'b0;
      pend           <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      pend <= (state == S_WALK);
      if (cfg_write) begin
        unique case (paddr[CFG_ADDR_W-1])
          REG_WEIGHT_EQUAL:   weight_equal   <= pwdata[WEIGHT_W-1:0];
          REG_WEIGHT_UNEQUAL: weight_unequal <= pwdata[WEIGHT_W-1:0];
          default: begin
          end
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_item.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + ADDR_W'(1);
          if (clr_cnt == ADDR_W'(CELLS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            priority if (in_item.kind == KIND_READ) begin
              state <= S_READ;
            end else if (in_item.kind == KIND_TRIAL) begin
              state <= S_CEN1;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_READ:  state <= S_DONE;
        S_CEN1:  state <= S_CEN2;
        S_CEN2: begin
          phase <= 1'b0;
          state <= S_WALK;
        end
        S_WALK: begin
          if (lcnt == WIN_LAST && kcnt == WIN_LAST) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: state <= S_SAVE;
        S_SAVE: begin
          if (!phase) begin
            phase <= 1'b1;
            state <= S_WALK;
          end else if (src_pot < acc) begin
            state <= S_SWAP1;
          end else begin
            state <= S_DONE;
          end
        end
        S_SWAP1: state <= S_SWAP2;
        S_SWAP2: state <= S_DONE;
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (pend) begin
      acc <= acc + POT_W'((ram_rdata == centre) ? weight_equal : weight_unequal);
    end
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          src_r         <= in_item.row;
          src_c         <= in_item.col;
          tgt_r         <= wrap_add(in_item.row, clamp_move(in_item.row_offset));
          tgt_c         <= wrap_add(in_item.col, clamp_move(in_item.col_offset));
          res_read_type <= '0;
          res_swapped   <= 1'b0;
          src_pot       <= '0;
          tgt_pot       <= '0;
        end
      end
      S_READ: res_read_type <= ram_rdata;
      S_CEN1: src_type <= ram_rdata;
      S_CEN2: tgt_type <= ram_rdata;
      S_WALK: begin
        if (lcnt == WIN_LAST) begin
          lcnt <= '0;
          kcnt <= kcnt + CNT_W'(1);
          wcol <= wcol_start;
          wrow <= coord_inc(wrow);
        end else begin
          lcnt <= lcnt + CNT_W'(1);
          wcol <= coord_inc(wcol);
        end
      end
      S_SAVE: begin
        if (!phase) begin
          src_pot <= acc;
        end else begin
          tgt_pot     <= acc;
          res_swapped <= (src_pot < acc);
        end
      end
      default: begin
      end
    endcase
    // Window walk setup, for the source after the centre reads and for the
    // target once the source sum is saved.
    if (state == S_CEN2 || (state == S_SAVE && !phase)) begin
      wrow       <= wrap_add(walk_base_r, WIN_BACK);
      wcol       <= wrap_add(walk_base_c, WIN_BACK);
      wcol_start <= wrap_add(walk_base_c, WIN_BACK);
      kcnt       <= '0;
      lcnt       <= '0;
      acc        <= '0;
    end
    if (out_load) begin
      out_read_type <= res_read_type;
      out_swapped   <= res_swapped;
      out_src_pot   <= src_pot;
      out_tgt_pot   <= tgt_pot;
    end
  end

endmodule
